### rtl/srx_pkg.sv
package srx_pkg;

  localparam int CountW = 17;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] STAT_NONE    = 2'd0;
  localparam logic [1:0] STAT_OK      = 2'd1;
  localparam logic [1:0] STAT_BAD_CRC = 2'd2;
  localparam logic [1:0] STAT_TIMEOUT = 2'd3;

  localparam logic [7:0]  HDR_SYNC  = 8'hFF;
  localparam logic [7:0]  HDR_LAST  = 8'hFD;
  localparam logic [15:0] CRC_POLY  = 16'h8005;

  localparam logic [CountW-1:0] POS_HDR1   = 17'd1;
  localparam logic [CountW-1:0] POS_HDR2   = 17'd2;
  localparam logic [CountW-1:0] POS_ID     = 17'd4;
  localparam logic [CountW-1:0] POS_LEN_LO = 17'd5;
  localparam logic [CountW-1:0] POS_LEN_HI = 17'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic [15:0] timeout_ticks;
  } srx_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              byte_valid;
    logic [CountW-1:0] byte_index;
    logic [7:0]        data_byte;
    logic [7:0]        packet_id;
  } srx_result_t;

  // one byte of the msb-first crc-16, polynomial 0x8005
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/srx_if.sv
interface srx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  rx_byte;
  logic [15:0] timeout_ticks;

  modport source (output valid, command, rx_byte, timeout_ticks, input ready);
  modport sink   (input valid, command, rx_byte, timeout_ticks, output ready);
endinterface

interface srx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        byte_valid;
  logic [16:0] byte_index;
  logic [7:0]  data_byte;
  logic [7:0]  packet_id;

  modport source (output valid, status, byte_valid, byte_index, data_byte, packet_id,
                  input ready);
  modport sink   (input valid, status, byte_valid, byte_index, data_byte, packet_id,
                  output ready);
endinterface

### rtl/srx_frame.sv
module srx_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  srx_pkg::srx_item_t  item,
  output srx_pkg::srx_result_t res
);
  import srx_pkg::*;

  logic              receiving_r, receiving_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [15:0]       remaining_r, remaining_nxt;
  logic [7:0]        len_lo_r, len_lo_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        tail0_r, tail0_nxt;
  logic [7:0]        tail1_r, tail1_nxt;
  logic [15:0]       elapsed_r, elapsed_nxt;
  logic [15:0]       limit_r, limit_nxt;

  logic              hdr_ok;
  logic              finish;
  logic [15:0]       rem_dec;

  always_comb begin
    receiving_nxt = receiving_r;
    count_nxt     = count_r;
    remaining_nxt = remaining_r;
    len_lo_nxt    = len_lo_r;
    id_nxt        = id_r;
    crc_nxt       = crc_r;
    tail0_nxt     = tail0_r;
    tail1_nxt     = tail1_r;
    elapsed_nxt   = elapsed_r;
    limit_nxt     = limit_r;
    res           = '0;
    finish        = 1'b0;
    rem_dec       = remaining_r - {15'd0, (remaining_r != 16'd0)};

    if (count_r <= POS_HDR1) begin
      hdr_ok = (item.rx_byte == HDR_SYNC);
    end else if (count_r == POS_HDR2) begin
      hdr_ok = (item.rx_byte == HDR_LAST);
    end else begin
      hdr_ok = 1'b1;
    end

    case (item.command)
      CMD_START: begin
        count_nxt     = '0;
        remaining_nxt = 16'd1;
        len_lo_nxt    = '0;
        id_nxt        = '0;
        crc_nxt       = '0;
        tail0_nxt     = '0;
        tail1_nxt     = '0;
        elapsed_nxt   = '0;
        limit_nxt     = item.timeout_ticks;
        if (item.timeout_ticks == 16'd0) begin
          receiving_nxt = 1'b0;
          res.status    = STAT_TIMEOUT;
        end else begin
          receiving_nxt = 1'b1;
        end
      end
      CMD_BYTE: begin
        if (receiving_r) begin
          if (!hdr_ok) begin
            count_nxt     = '0;
            remaining_nxt = 16'd1;
            len_lo_nxt    = '0;
            id_nxt        = '0;
            crc_nxt       = '0;
            tail0_nxt     = '0;
            tail1_nxt     = '0;
          end else begin
            res.byte_valid = 1'b1;
            res.byte_index = count_r;
            res.data_byte  = item.rx_byte;
            if (count_r == POS_ID) begin
              id_nxt = item.rx_byte;
            end
            if (count_r == POS_LEN_LO) begin
              len_lo_nxt = item.rx_byte;
            end
            if (count_r >= POS_HDR2) begin
              crc_nxt = crc16_byte(crc_r, tail0_r);
            end
            tail0_nxt = tail1_r;
            tail1_nxt = item.rx_byte;
            count_nxt = count_r + 1'b1;
            if (count_r == POS_LEN_HI) begin
              remaining_nxt = {item.rx_byte, len_lo_r};
              finish        = ({item.rx_byte, len_lo_r} == 16'd0);
            end else if (count_r > POS_LEN_HI) begin
              remaining_nxt = rem_dec;
              finish        = (rem_dec == 16'd0);
            end
            if (finish) begin
              res.status    = ({item.rx_byte, tail1_r} == crc_nxt) ? STAT_OK : STAT_BAD_CRC;
              res.packet_id = id_r;
              receiving_nxt = 1'b0;
            end
          end
        end
      end
      CMD_TICK: begin
        if (receiving_r) begin
          elapsed_nxt = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
          if (elapsed_nxt >= limit_r) begin
            res.status    = STAT_TIMEOUT;
            res.packet_id = id_r;
            receiving_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      count_r     <= '0;
      remaining_r <= 16'd1;
      len_lo_r    <= '0;
      id_r        <= '0;
      crc_r       <= '0;
      tail0_r     <= '0;
      tail1_r     <= '0;
      elapsed_r   <= '0;
      limit_r     <= '0;
    end else if (step) begin
      receiving_r <= receiving_nxt;
      count_r     <= count_nxt;
      remaining_r <= remaining_nxt;
      len_lo_r    <= len_lo_nxt;
      id_r        <= id_nxt;
      crc_r       <= crc_nxt;
      tail0_r     <= tail0_nxt;
      tail1_r     <= tail1_nxt;
      elapsed_r   <= elapsed_nxt;
      limit_r     <= limit_nxt;
    end
  end

endmodule

### rtl/servo_packet_receiver_crc16.sv
// Servo-bus packet receiver. A start transaction arms reception with a tick
// timeout; byte transactions are matched against the FF FF FD header, then
// reserved byte, ID, little-endian length L and L further bytes, with a
// CRC-16 (poly 0x8005, msb first, initial 0) over all but the last two bytes,
// which carry the expected CRC low byte first. Every transaction gives exactly
// one result: each stored byte is echoed with its index, and the final byte
// or the expiring tick reports ok, CRC mismatch or timeout with the packet ID;
// a start with a zero timeout reports timeout at once. One transaction is
// taken per clock while the result side does not stall; each passes through
// the input register and then the result register around the combinational
// header/CRC/length logic. Back-pressure on the result side stalls the input
// side only once both registers are full.
module servo_packet_receiver_crc16 (
  input logic     clk,
  input logic     rst_n,
  srx_in_if.sink  in_ch,
  srx_out_if.source out_ch
);
  import srx_pkg::*;

  logic        s1_valid_r;
  srx_item_t   s1_item_r;
  logic        out_valid_r;
  srx_result_t out_res_r;
  srx_result_t res;
  logic        advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.command       <= in_ch.command;
      s1_item_r.rx_byte       <= in_ch.rx_byte;
      s1_item_r.timeout_ticks <= in_ch.timeout_ticks;
    end
  end

  srx_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_res_r.status;
  assign out_ch.byte_valid = out_res_r.byte_valid;
  assign out_ch.byte_index = out_res_r.byte_index;
  assign out_ch.data_byte  = out_res_r.data_byte;
  assign out_ch.packet_id  = out_res_r.packet_id;

endmodule

### rtl/srx_checker.sv
module srx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        byte_valid,
  input logic [16:0] byte_index,
  input logic [7:0]  data_byte,
  input logic [7:0]  packet_id
);
  import srx_pkg::*;

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(byte_valid)
      && $stable(byte_index) && $stable(data_byte) && $stable(packet_id))
    else $error("result changed while stalled");

  a_no_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> byte_index == '0 && data_byte == '0)
    else $error("index or data set without a stored byte");

  a_crc_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STAT_OK || status == STAT_BAD_CRC)
      |-> byte_valid && byte_index >= 17'd6)
    else $error("crc verdict without a closing packet byte");

  a_idle_pid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_NONE |-> packet_id == '0)
    else $error("packet id given without a final status");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind servo_packet_receiver_crc16 srx_checker u_srx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .byte_valid (out_ch.byte_valid),
  .byte_index (out_ch.byte_index),
  .data_byte  (out_ch.data_byte),
  .packet_id  (out_ch.packet_id)
);
